// File: sv/abs_pkg.sv
// abs_pkg: shared widths and the job record of the aligned block splitter.
// Used by the front end, the job queue, the back end and the top level.
package abs_pkg;

	// Fixed field widths of the frame and run results
	localparam int PFN_W = 36;
	localparam int ORD_W = 4;
	localparam int CNT_W = 37;

	// One classified range handed from the front end to the back end
	typedef struct packed {
		logic             empty;  // nothing to release, single empty result
		logic [PFN_W-1:0] pfn;    // first frame of the range
		logic [PFN_W-1:0] rem;    // frames in the range
	} abs_job_t;

endpackage

// File: sv/abs_if.sv
// abs_if: valid/ready channels of the aligned block splitter.
// Depends on abs_pkg for the fixed result widths.

// Range request channel
interface abs_in_if #(parameter int ADDR_BITS = 48);
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] range_start;
	logic [ADDR_BITS-1:0] range_end;

	modport source (output valid, output range_start, output range_end, input ready);
	modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

// Run result channel
interface abs_out_if;
	logic                       valid;
	logic                       ready;
	logic [abs_pkg::PFN_W-1:0]  run_pfn;
	logic [abs_pkg::ORD_W-1:0]  run_order;
	logic [abs_pkg::CNT_W-1:0]  run_count;
	logic [abs_pkg::PFN_W-1:0]  range_pages;
	logic                       last;

	modport source (output valid, output run_pfn, output run_order, output run_count,
		output range_pages, output last, input ready);
	modport sink   (input valid, input run_pfn, input run_order, input run_count,
		input range_pages, input last, output ready);
endinterface

// Limit register write channel
interface abs_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [abs_pkg::PFN_W-1:0] low_pfn_limit;

	modport source (output valid, output low_pfn_limit, input ready);
	modport sink   (input valid, input low_pfn_limit, output ready);
endinterface

// File: sv/abs_front.sv
// abs_front: takes range requests, rounds them to frames, clamps to the limit.
// Depends on abs_pkg and abs_if; holds the low_pfn_limit register.
module abs_front #(
	parameter int ADDR_BITS  = 48,
	parameter int PAGE_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	abs_in_if.sink            range_ch,
	abs_cfg_if.sink           cfg_ch,
	output logic              job_valid,
	input  logic              job_ready,
	output abs_pkg::abs_job_t job
);
	import abs_pkg::*;

	localparam int FW = ADDR_BITS - PAGE_SHIFT;     // floor frame width
	localparam int SW = FW + 1;                     // rounded-up start may carry
	localparam int CW = (FW > PFN_W) ? FW : PFN_W;  // end clamp compare width
	localparam int DW = (SW > PFN_W) ? SW : PFN_W;  // empty test width

	logic [PFN_W-1:0] limit_q;
	logic             vld_s1;
	logic [SW-1:0]    s_s1;
	logic [PFN_W-1:0] e_s1;
	logic [SW-1:0]    s_nxt;
	logic [FW-1:0]    ef;
	logic [PFN_W-1:0] e_nxt;
	logic             take;

	// Limit register, always writable
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_ch.valid) begin
			limit_q <= cfg_ch.low_pfn_limit;
		end
	end

	// Start rounds up, end rounds down and is clamped
	assign s_nxt = SW'(range_ch.range_start[ADDR_BITS-1:PAGE_SHIFT])
		+ SW'(|range_ch.range_start[PAGE_SHIFT-1:0]);
	assign ef    = range_ch.range_end[ADDR_BITS-1:PAGE_SHIFT];
	assign e_nxt = (CW'(ef) > CW'(limit_q)) ? limit_q : PFN_W'(ef);

	assign range_ch.ready = !vld_s1 || job_ready;
	assign take           = range_ch.valid && range_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (range_ch.ready) begin
			vld_s1 <= range_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s_s1 <= s_nxt;
			e_s1 <= e_nxt;
		end
	end

	// Classify: empty when the start has reached the end
	assign job_valid = vld_s1;
	assign job.empty = DW'(s_s1) >= DW'(e_s1);
	assign job.pfn   = PFN_W'(s_s1);
	assign job.rem   = e_s1 - PFN_W'(s_s1);

endmodule

// File: sv/abs_queue.sv
// abs_queue: two-entry job queue between the front end and the back end.
// Depends on abs_pkg for the job record.
module abs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  abs_pkg::abs_job_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output abs_pkg::abs_job_t pop_data
);
	import abs_pkg::*;

	abs_job_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: sv/abs_back.sv
// abs_back: walks a frame range in aligned blocks, merges runs and takes a new job only when idle.
// Depends on abs_pkg and abs_if; drives the registered result channel.
module abs_back #(
	parameter int MAX_ORDER = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  abs_pkg::abs_job_t job,
	abs_out_if.source         run_ch
);
	import abs_pkg::*;

	localparam int OW = $clog2(MAX_ORDER + 2);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} back_state_t;

	back_state_t      state_q, state_nxt;
	logic [PFN_W-1:0] pfn_q, rem_q, pages_q;
	logic             cur_vld_q;
	logic [PFN_W-1:0] cur_pfn_q;
	logic [OW-1:0]    cur_ord_q;
	logic [CNT_W-1:0] cur_cnt_q;
	logic             out_vld_q;
	logic [PFN_W-1:0] out_pfn_q, out_pages_q;
	logic [ORD_W-1:0] out_ord_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic             out_last_q;

	logic [OW-1:0]    tz, fit, blk_ord;
	logic             is_max;
	logic [CNT_W-1:0] blk_cnt;
	logic [PFN_W-1:0] blk_step;
	logic             out_free, load, start, merge, emit, emit_run;

	// Block order: trailing zeros, capped, limited by what still fits
	always_comb begin
		tz = OW'(MAX_ORDER);
		for (int i = MAX_ORDER - 1; i >= 0; i--) begin
			if (pfn_q[i]) tz = OW'(i);
		end
		fit = '0;
		if (|(rem_q >> MAX_ORDER)) begin
			fit = OW'(MAX_ORDER);
		end else begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				if (rem_q[i]) fit = OW'(i);
			end
		end
		blk_ord = (tz < fit) ? tz : fit;
	end

	// Top-order blocks are taken all at once
	assign is_max   = blk_ord == OW'(MAX_ORDER);
	assign blk_cnt  = is_max ? CNT_W'(rem_q >> MAX_ORDER) : CNT_W'(1);
	assign blk_step = is_max ? ((rem_q >> MAX_ORDER) << MAX_ORDER) : (PFN_W'(1) << blk_ord);

	assign out_free = !out_vld_q || run_ch.ready;

	// Sequencer
	always_comb begin
		state_nxt = state_q;
		job_ready = 1'b0;
		load      = 1'b0;
		start     = 1'b0;
		merge     = 1'b0;
		emit      = 1'b0;
		emit_run  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					if (!job.empty) begin
						job_ready = 1'b1;
						load      = 1'b1;
						state_nxt = ST_RUN;
					end else if (out_free) begin
						job_ready = 1'b1;
						emit      = 1'b1;
					end
				end
			end
			ST_RUN: begin
				priority if (rem_q == '0) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_run  = 1'b1;
						state_nxt = ST_IDLE;
					end
				end else if (cur_vld_q && blk_ord == cur_ord_q) begin
					merge = 1'b1;
				end else if (!cur_vld_q) begin
					start = 1'b1;
				end else if (out_free) begin
					emit     = 1'b1;
					emit_run = 1'b1;
					start    = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load)       cur_vld_q <= 1'b0;
			else if (start) cur_vld_q <= 1'b1;
			if (emit)              out_vld_q <= 1'b1;
			else if (run_ch.ready) out_vld_q <= 1'b0;
		end
	end

	// Range walk and open run
	always_ff @(posedge clk) begin
		if (load) begin
			pfn_q   <= job.pfn;
			rem_q   <= job.rem;
			pages_q <= job.rem;
		end else if (start || merge) begin
			pfn_q <= pfn_q + blk_step;
			rem_q <= rem_q - blk_step;
		end
		if (start) begin
			cur_pfn_q <= pfn_q;
			cur_ord_q <= blk_ord;
			cur_cnt_q <= blk_cnt;
		end else if (merge) begin
			cur_cnt_q <= cur_cnt_q + blk_cnt;
		end
	end

	// Result register; the last run also carries the page total
	always_ff @(posedge clk) begin
		if (emit) begin
			out_pfn_q   <= emit_run ? cur_pfn_q : '0;
			out_ord_q   <= emit_run ? ORD_W'(cur_ord_q) : '0;
			out_cnt_q   <= emit_run ? cur_cnt_q : '0;
			out_pages_q <= (state_q == ST_RUN && rem_q == '0) ? pages_q : '0;
			out_last_q  <= !(state_q == ST_RUN && rem_q != '0);
		end
	end

	assign run_ch.valid       = out_vld_q;
	assign run_ch.run_pfn     = out_pfn_q;
	assign run_ch.run_order   = out_ord_q;
	assign run_ch.run_count   = out_cnt_q;
	assign run_ch.range_pages = out_pages_q;
	assign run_ch.last        = out_last_q;

endmodule

// File: sv/aligned_block_splitter.sv
// Aligned block splitter usage notes.
// range_ch takes a byte range (range_start, range_end). The start rounds up
// and the end rounds down to page frames; the end is clamped to the
// low_pfn_limit register, written over cfg_ch (always ready, reset all ones).
// run_ch gives one request per run of equal-order aligned blocks: run_pfn,
// run_order, run_count. The final run of a range has last set and carries
// range_pages; an empty range gives one all-zero request with last set.
// Flow: the front end registers the rounded and clamped range and hands a job
// to a two-entry queue. The back end loads a job, walks the range in steps (all
// top-order blocks of a range form one step; at most 2*MAX_ORDER+1 steps) and
// then closes the range; an empty range is only emitted, with no walk.
// Results pass through the front-end register, the queue entry and the result
// register, runs also through the walk registers; the queue delays them when busy.
// The block walk is the limiting loop: the next range waits in the queue.
// A stalled receiver holds the result register; the back end stops when it
// must emit, and the queue then fills and deasserts range_ch.ready.
// Reset clears the queue, the sequencer and the result valid.
// Depends on abs_pkg, abs_if, abs_front, abs_queue and abs_back.
module aligned_block_splitter #(
	parameter int MAX_ORDER  = 10,
	parameter int PAGE_SHIFT = 12,
	parameter int ADDR_BITS  = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	abs_in_if.sink     range_ch,
	abs_cfg_if.sink    cfg_ch,
	abs_out_if.source  run_ch
);
	import abs_pkg::*;

	logic     fq_valid, fq_ready;
	abs_job_t fq_job;
	logic     qb_valid, qb_ready;
	abs_job_t qb_job;

	// Round, clamp and classify
	abs_front #(
		.ADDR_BITS  (ADDR_BITS),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.range_ch  (range_ch),
		.cfg_ch    (cfg_ch),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	// Decoupling queue
	abs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_job)
	);

	// Block walk and run output
	abs_back #(
		.MAX_ORDER (MAX_ORDER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.run_ch    (run_ch)
	);

endmodule
